// File: src/bae_pkg.sv
// Shared types, limits and checksum helpers for the bech32 address encoder.
package bae_pkg;

  localparam int unsigned PLEN_W = 7;
  localparam int unsigned PROG_W = 6;
  localparam int unsigned CSUM_W = 30;

  localparam logic [PLEN_W-1:0] PREFIX_MAX  = 7'd83;
  localparam logic [PROG_W-1:0] PROGRAM_MAX = 6'd40;
  localparam logic [7:0]        VERSION_MAX = 8'd16;
  localparam logic [7:0]        CASE_OFFSET = 8'h20;
  localparam logic [7:0]        CHAR_ONE    = 8'h31;
  localparam logic [CSUM_W-1:0] CSUM_INIT   = 30'd1;

  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QDEPTH = 1 << QPTR_W;

  localparam logic [CSUM_W-1:0] GEN_POLY [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  localparam logic [255:0] B32_ALPHA = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef enum logic [1:0] {
    OP_PREFIX  = 2'd0,
    OP_VERSION = 2'd1,
    OP_PROGRAM = 2'd2
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_PREFIX  = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_BAD_PROGRAM = 3'd3,
    ST_BAD_ORDER   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_PROGRAM,
    PH_DISCARD
  } phase_t;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_VERSION,
    CMD_BYTE,
    CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [7:0]         value;
    logic               last;
    status_t            status;
    logic [PLEN_W-1:0]  plen;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_WALK_HI,
    BK_MIX_SEP,
    BK_WALK_LO,
    BK_VERSION,
    BK_GROUP,
    BK_PAD,
    BK_FINAL_MIX,
    BK_CHECKSUM
  } bk_state_t;

  // One step of the BCH polynomial over GF(32).
  function automatic logic [CSUM_W-1:0] bch_mix(input logic [CSUM_W-1:0] c,
                                                input logic [4:0] v);
    logic [4:0]        top;
    logic [CSUM_W-1:0] r;
    top = c[29:25];
    r   = {c[24:0], v};
    for (int j = 0; j < 5; j++) begin
      if (top[j]) r = r ^ GEN_POLY[j];
    end
    return r;
  endfunction

  function automatic logic [7:0] b32_char(input logic [4:0] g);
    logic [7:0] base;
    base = {~g, 3'b000};
    return B32_ALPHA[base +: 8];
  endfunction

endpackage

// File: src/bae_front.sv
// Front end: accepts input items, checks frame order and lengths, issues commands.
module bae_front import bae_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_value,
  input  logic       in_last,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  phase_t            phase, phase_next;
  logic [PLEN_W-1:0] plen, plen_next;
  logic [PROG_W-1:0] prog, prog_next;
  logic              accept;
  logic              is_err;
  status_t           err_code;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the item against the frame state.
  always_comb begin
    is_err   = 1'b0;
    err_code = ST_OK;
    case (phase)
      PH_PREFIX: begin
        if (in_opcode == OP_PREFIX) begin
          if (in_last) begin
            is_err = 1'b1; err_code = ST_BAD_ORDER;
          end else if (plen >= PREFIX_MAX) begin
            is_err = 1'b1; err_code = ST_BAD_PREFIX;
          end
        end else if (in_opcode != OP_VERSION) begin
          is_err = 1'b1; err_code = ST_BAD_ORDER;
        end else if (plen == '0) begin
          is_err = 1'b1; err_code = ST_BAD_PREFIX;
        end else if (in_value > VERSION_MAX) begin
          is_err = 1'b1; err_code = ST_BAD_VERSION;
        end else if (in_last) begin
          is_err = 1'b1; err_code = ST_BAD_PROGRAM;
        end
      end
      PH_PROGRAM: begin
        if (in_opcode != OP_PROGRAM) begin
          is_err = 1'b1; err_code = ST_BAD_ORDER;
        end else if (prog >= PROGRAM_MAX) begin
          is_err = 1'b1; err_code = ST_BAD_PROGRAM;
        end else if (in_last && prog == '0) begin
          is_err = 1'b1; err_code = ST_BAD_PROGRAM;
        end
      end
      default: begin
        is_err   = 1'b0;
        err_code = ST_OK;
      end
    endcase
  end

  // Next state.
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (in_last) begin
        phase_next = PH_PREFIX;
      end else if (phase != PH_DISCARD) begin
        if (is_err) begin
          phase_next = PH_DISCARD;
        end else if (phase == PH_PREFIX && in_opcode == OP_VERSION) begin
          phase_next = PH_PROGRAM;
        end
      end
    end
  end

  // Commands and counters.
  always_comb begin
    q_push        = 1'b0;
    q_cmd.kind    = CMD_ERROR;
    q_cmd.value   = in_value;
    q_cmd.last    = in_last;
    q_cmd.status  = err_code;
    q_cmd.plen    = plen;
    plen_next     = plen;
    prog_next     = prog;
    if (accept && phase != PH_DISCARD) begin
      q_push = 1'b1;
      if (is_err) begin
        q_cmd.kind = CMD_ERROR;
      end else if (phase == PH_PREFIX && in_opcode == OP_PREFIX) begin
        q_cmd.kind = CMD_CHAR;
        if (in_value inside {[8'h41:8'h5a]}) q_cmd.value = in_value + CASE_OFFSET;
        plen_next = plen + 1'b1;
      end else if (phase == PH_PREFIX) begin
        q_cmd.kind = CMD_VERSION;
      end else begin
        q_cmd.kind = CMD_BYTE;
        prog_next  = prog + 1'b1;
      end
    end
    // Start a fresh frame after any last mark.
    if (accept && in_last) begin
      plen_next = '0;
      prog_next = '0;
    end else if (accept && is_err) begin
      plen_next = plen;
      prog_next = prog;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PREFIX;
      plen  <= '0;
      prog  <= '0;
    end else begin
      phase <= phase_next;
      plen  <= plen_next;
      prog  <= prog_next;
    end
  end

endmodule

// File: src/bae_fifo.sv
// Short command queue between the front end and the back end.
module bae_fifo import bae_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_cmd
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push, do_pop;

  assign full      = (count == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/bae_back.sv
// Back end: prefix store, checksum engine, 5-bit regrouping and the output register.
module bae_back import bae_pkg::*; #(
  parameter int unsigned PREFIX_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CSUM_W-1:0] cconst,
  input  logic              cmd_valid,
  input  cmd_t              cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_char,
  output logic              out_eos,
  output logic [2:0]        out_status
);

  localparam int unsigned PW = $clog2(PREFIX_DEPTH);

  logic [7:0]        mem [PREFIX_DEPTH];
  logic [7:0]        rdata;
  logic              rd_en, wr_en;

  bk_state_t         state, state_next;
  logic [CSUM_W-1:0] csum, csum_next;
  logic [11:0]       acc, acc_next;
  logic [3:0]        cnt, cnt_next;
  logic [7:0]        val, val_next;
  logic              last_flag, last_flag_next;
  logic [PLEN_W-1:0] plen, plen_next;
  logic [PLEN_W-1:0] idx, idx_next;
  logic              rd_pend, rd_pend_next;
  logic [2:0]        step, step_next;

  logic              out_free;
  logic              emit;
  logic [7:0]        emit_char;
  logic              emit_eos;
  status_t           emit_status;
  logic [11:0]       grp_shift, pad_shift;
  logic [11:0]       acc_in;
  logic              walk_done;

  assign out_free  = !out_valid || out_ready;
  assign grp_shift = acc >> (cnt - 4'd5);
  assign pad_shift = acc << (4'd5 - cnt);
  assign acc_in    = {acc[3:0], cmd.value};
  assign walk_done = (idx == plen) && !rd_pend;

  always_ff @(posedge clk) begin
    if (wr_en) mem[PW'(cmd.plen)] <= cmd.value;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[PW'(idx)];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == CMD_BYTE) state_next = BK_GROUP;
          else if (cmd.kind == CMD_VERSION && out_free) state_next = BK_WALK_HI;
        end
      end
      BK_WALK_HI:   if (walk_done) state_next = BK_MIX_SEP;
      BK_MIX_SEP:   state_next = BK_WALK_LO;
      BK_WALK_LO:   if (walk_done) state_next = BK_VERSION;
      BK_VERSION:   if (out_free) state_next = BK_IDLE;
      BK_GROUP: begin
        if (cnt < 4'd5) state_next = last_flag ? BK_PAD : BK_IDLE;
      end
      BK_PAD:       if (cnt == '0 || out_free) state_next = BK_FINAL_MIX;
      BK_FINAL_MIX: if (step == 3'd5) state_next = BK_CHECKSUM;
      BK_CHECKSUM:  if (out_free && step == 3'd5) state_next = BK_IDLE;
      default:      state_next = BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cmd_pop        = 1'b0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    emit           = 1'b0;
    emit_char      = 8'd0;
    emit_eos       = 1'b0;
    emit_status    = ST_OK;
    csum_next      = csum;
    acc_next       = acc;
    cnt_next       = cnt;
    val_next       = val;
    last_flag_next = last_flag;
    plen_next      = plen;
    idx_next       = idx;
    rd_pend_next   = 1'b0;
    step_next      = step;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_CHAR: begin
              if (out_free) begin
                cmd_pop   = 1'b1;
                wr_en     = 1'b1;
                emit      = 1'b1;
                emit_char = cmd.value;
              end
            end
            CMD_VERSION: begin
              if (out_free) begin
                cmd_pop   = 1'b1;
                emit      = 1'b1;
                emit_char = CHAR_ONE;
                val_next  = cmd.value;
                plen_next = cmd.plen;
                idx_next  = '0;
              end
            end
            CMD_BYTE: begin
              cmd_pop        = 1'b1;
              acc_next       = acc_in;
              cnt_next       = cnt + 4'd8;
              last_flag_next = cmd.last;
            end
            default: begin
              if (out_free) begin
                cmd_pop     = 1'b1;
                emit        = 1'b1;
                emit_eos    = 1'b1;
                emit_status = cmd.status;
                csum_next   = CSUM_INIT;
                acc_next    = '0;
                cnt_next    = '0;
              end
            end
          endcase
        end
      end
      BK_WALK_HI, BK_WALK_LO: begin
        // Keep one read in flight and fold the returned character.
        if (idx != plen) begin
          rd_en        = 1'b1;
          idx_next     = idx + 1'b1;
          rd_pend_next = 1'b1;
        end
        if (rd_pend) begin
          csum_next = bch_mix(csum, (state == BK_WALK_HI) ? {2'b00, rdata[7:5]}
                                                          : rdata[4:0]);
        end
      end
      BK_MIX_SEP: begin
        csum_next = bch_mix(csum, 5'd0);
        idx_next  = '0;
      end
      BK_VERSION: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = b32_char(val[4:0]);
          csum_next = bch_mix(csum, val[4:0]);
        end
      end
      BK_GROUP: begin
        if (cnt >= 4'd5) begin
          if (out_free) begin
            emit      = 1'b1;
            emit_char = b32_char(grp_shift[4:0]);
            csum_next = bch_mix(csum, grp_shift[4:0]);
            cnt_next  = cnt - 4'd5;
          end
        end else begin
          // Drop the bits already sent.
          acc_next = acc & ~(12'hfff << cnt);
        end
      end
      BK_PAD: begin
        step_next = '0;
        if (cnt != '0 && out_free) begin
          emit      = 1'b1;
          emit_char = b32_char(pad_shift[4:0]);
          csum_next = bch_mix(csum, pad_shift[4:0]);
          cnt_next  = '0;
        end
      end
      BK_FINAL_MIX: begin
        csum_next = bch_mix(csum, 5'd0);
        step_next = step + 1'b1;
        if (step == 3'd5) begin
          csum_next = bch_mix(csum, 5'd0) ^ cconst;
          step_next = '0;
        end
      end
      BK_CHECKSUM: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = b32_char(csum[29:25]);
          emit_eos  = (step == 3'd5);
          csum_next = {csum[24:0], 5'd0};
          step_next = step + 1'b1;
          if (step == 3'd5) begin
            csum_next = CSUM_INIT;
            acc_next  = '0;
            cnt_next  = '0;
            step_next = '0;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      csum      <= CSUM_INIT;
      acc       <= '0;
      cnt       <= '0;
      last_flag <= 1'b0;
      plen      <= '0;
      idx       <= '0;
      rd_pend   <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      csum      <= csum_next;
      acc       <= acc_next;
      cnt       <= cnt_next;
      last_flag <= last_flag_next;
      plen      <= plen_next;
      idx       <= idx_next;
      rd_pend   <= rd_pend_next;
      step      <= step_next;
      if (out_free) out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    if (emit && out_free) begin
      out_char   <= emit_char;
      out_eos    <= emit_eos;
      out_status <= emit_status;
    end
  end

endmodule

// File: src/bech32_address_encoder_top.sv
// Bech32 / bech32m segwit address encoder, streaming top level.
//
// Feed a frame as prefix characters (tuser 0), one witness version (tuser 1)
// and program bytes (tuser 2, tlast on the last one). Each prefix character
// comes out lower-cased, registered in the command queue and then in the
// output register. The version item emits '1' at once and the version
// character after two walks of the stored prefix, paced by the single read
// port of the prefix store and the one-step-per-cycle checksum unit. Each
// program byte emits one character per complete 5-bit group, and the last
// byte adds a padded group if bits remain, six checksum steps and six
// checksum characters. Output stalls hold the back end wherever it emits.
// A four-entry command queue lets input continue while the back end works.
// An error result has tdata 0, tlast 1 and the status in tuser; discard the
// text already sent for that frame.
// cfg_wdata selects the final XOR constant (1 bech32, 0x2bc830a3 bech32m).
// Write it only while the block is idle; the block does not enforce this.
module bech32_address_encoder_top import bae_pkg::*; #(
  parameter int unsigned PREFIX_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] item_value
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] output_char
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [29:0] cfg_wdata
);

  logic [CSUM_W-1:0] cconst;
  logic              q_push, q_full, q_pop, q_not_empty;
  cmd_t              q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cconst <= CSUM_INIT;
    end else if (cfg_we) begin
      cconst <= cfg_wdata;
    end
  end

  bae_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_opcode (s_tuser),
    .in_value  (s_tdata),
    .in_last   (s_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  bae_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_out)
  );

  bae_back #(
    .PREFIX_DEPTH (PREFIX_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cconst     (cconst),
    .cmd_valid  (q_not_empty),
    .cmd        (q_out),
    .cmd_pop    (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_char   (m_tdata),
    .out_eos    (m_tlast),
    .out_status (m_tuser)
  );

endmodule

// File: src/bae_checker.sv
// Port-level checks for the bech32 address encoder, bound to the top level.
module bae_checker import bae_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output changed while stalled");

  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tlast && m_tdata == 8'd0)
    else $error("error result without end mark or with nonzero char");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_BAD_PREFIX
              || m_tuser == ST_BAD_VERSION || m_tuser == ST_BAD_PROGRAM
              || m_tuser == ST_BAD_ORDER)
    else $error("status code out of range");

  a_ok_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_OK |-> m_tdata != 8'd0 || !m_tlast)
    else $error("final character of a good address is zero");

  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind bech32_address_encoder_top bae_checker u_bae_checker (.*);
